// File: sv/pgftl_pkg.sv
// shared constants, types and operation codes of the page-mapped translation core
`timescale 1ns / 1ps
package pgftl_pkg;
   localparam int NUM_BLOCKS      = 64;
   localparam int PAGES_PER_BLOCK = 32;
   localparam int NUM_KEYS        = 1024;

   localparam int BLK_W  = $clog2(NUM_BLOCKS);
   localparam int PG_W   = $clog2(PAGES_PER_BLOCK);
   localparam int KEY_W  = $clog2(NUM_KEYS);
   localparam int CNT_W  = $clog2(PAGES_PER_BLOCK + 1);
   localparam int FREE_W = $clog2(NUM_BLOCKS + 1);
   localparam int PIDX_W = BLK_W + PG_W;
   localparam int MAP_W  = 1 + BLK_W + PG_W;
   localparam int COPY_W = 32;

   typedef enum logic [1:0] {
      ALU_DEC_SAT,
      ALU_INC,
      ALU_LT
   } alu_op_type;

   typedef struct packed {
      logic [CNT_W-1:0] res;
      logic             flag;
   } alu_res_type;

   typedef struct packed {
      logic             ok;
      logic [BLK_W-1:0] blk;
      logic [PG_W-1:0]  pg;
   } map_entry_type;
endpackage

// File: sv/page_mapped_ftl_greedy_gc_core.sv
// a read looks up the map and returns its entry; a write retires the old page, may collect, then appends
// a collection scans the blocks for a victim, then copies each live victim page into the current block
// throughput: one item at a time, busy stays high until the result strobe
// every step goes through one sequencer, one count unit and one write port and one read port per memory
// reset: synchronous; afterwards a clearing pass over every page index holds busy high
// the receiver cannot stall: each result is shown for one cycle on rsp_valid
`timescale 1ns / 1ps
module page_mapped_ftl_greedy_gc_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [pgftl_pkg::KEY_W-1:0]         req_key,
   output logic                                rsp_valid,
   output logic                                rsp_found,
   output logic [pgftl_pkg::BLK_W-1:0]         rsp_phys_block,
   output logic [pgftl_pkg::PG_W-1:0]          rsp_phys_page,
   output logic                                rsp_gc_ran,
   output logic [pgftl_pkg::COPY_W-1:0]        rsp_copy_count
);
   localparam int BLK_W  = pgftl_pkg::BLK_W;
   localparam int PG_W   = pgftl_pkg::PG_W;
   localparam int KEY_W  = pgftl_pkg::KEY_W;
   localparam int CNT_W  = pgftl_pkg::CNT_W;
   localparam int FREE_W = pgftl_pkg::FREE_W;
   localparam int PIDX_W = pgftl_pkg::PIDX_W;
   localparam int MAP_W  = pgftl_pkg::MAP_W;
   localparam int COPY_W = pgftl_pkg::COPY_W;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_RD, S_W_MAP, S_W_OLD, S_GC_CHK, S_GC_CUR, S_SCAN_RD,
      S_SCAN_CMP, S_GC_DEC, S_CP_RD, S_CP_WR, S_CP_CLR, S_FIN_VIC, S_FIN_CUR,
      S_AP_RD, S_AP_WR
   } state_type;

   state_type state_ff, state_in;
   logic [PIDX_W-1:0] clr_ff, clr_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [BLK_W-1:0]  ob_ff, ob_in;
   logic [PG_W-1:0]   opg_ff, opg_in;
   logic [BLK_W-1:0]  cur_ff, cur_in;
   logic [BLK_W-1:0]  fol_ff, fol_in;
   logic              none_ff, none_in;
   logic [FREE_W-1:0] free_ff, free_in;
   logic [COPY_W-1:0] copies_ff, copies_in;
   logic [BLK_W-1:0]  scan_ff, scan_in;
   logic [CNT_W-1:0]  best_ff, best_in;
   logic [BLK_W-1:0]  vic_ff, vic_in;
   logic              have_ff, have_in;
   logic [CNT_W-1:0]  cwp_ff, cwp_in;
   logic [CNT_W-1:0]  cvc_ff, cvc_in;
   logic [PG_W-1:0]   page_ff, page_in;
   logic              gc_ff, gc_in;
   logic              adv_ff, adv_in;
   logic              rv_ff, rv_in;
   logic              rf_ff, rf_in;
   logic [BLK_W-1:0]  rb_ff, rb_in;
   logic [PG_W-1:0]   rp_ff, rp_in;
   logic              rg_ff, rg_in;

   // memory ports
   logic              map_we;
   logic [KEY_W-1:0]  map_waddr, map_raddr;
   logic [MAP_W-1:0]  map_wdata, map_rdata;
   logic              pkey_we;
   logic [PIDX_W-1:0] pkey_waddr, pkey_raddr;
   logic [KEY_W-1:0]  pkey_wdata, pkey_rdata;
   logic              pval_we;
   logic [PIDX_W-1:0] pval_waddr, pval_raddr;
   logic              pval_wdata, pval_rdata;
   logic              bvc_we;
   logic [BLK_W-1:0]  bvc_waddr, bvc_raddr;
   logic [CNT_W-1:0]  bvc_wdata, bvc_rdata;
   logic              wptr_we;
   logic [BLK_W-1:0]  wptr_waddr, wptr_raddr;
   logic [CNT_W-1:0]  wptr_wdata, wptr_rdata;

   pgftl_pkg::alu_op_type  alu_op;
   logic [CNT_W-1:0]       alu_a, alu_b;
   pgftl_pkg::alu_res_type alu_res;

   pgftl_pkg::map_entry_type map_rd, map_wr;

   // block pointer advance
   logic [BLK_W-1:0]  adv_cur, adv_fol;
   logic              adv_none;
   logic [FREE_W-1:0] adv_free;
   logic [CNT_W:0]    need;

   pgftl_ram #(.WIDTH(MAP_W), .ADDR_W(KEY_W)) u_map (
      .clock(clock), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
      .raddr(map_raddr), .rdata(map_rdata)
   );
   pgftl_ram #(.WIDTH(KEY_W), .ADDR_W(PIDX_W)) u_pkey (
      .clock(clock), .we(pkey_we), .waddr(pkey_waddr), .wdata(pkey_wdata),
      .raddr(pkey_raddr), .rdata(pkey_rdata)
   );
   pgftl_ram #(.WIDTH(1), .ADDR_W(PIDX_W)) u_pval (
      .clock(clock), .we(pval_we), .waddr(pval_waddr), .wdata(pval_wdata),
      .raddr(pval_raddr), .rdata(pval_rdata)
   );
   pgftl_ram #(.WIDTH(CNT_W), .ADDR_W(BLK_W)) u_bvc (
      .clock(clock), .we(bvc_we), .waddr(bvc_waddr), .wdata(bvc_wdata),
      .raddr(bvc_raddr), .rdata(bvc_rdata)
   );
   pgftl_ram #(.WIDTH(CNT_W), .ADDR_W(BLK_W)) u_wptr (
      .clock(clock), .we(wptr_we), .waddr(wptr_waddr), .wdata(wptr_wdata),
      .raddr(wptr_raddr), .rdata(wptr_rdata)
   );
   pgftl_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .result(alu_res));

   assign map_rd    = map_rdata;
   assign map_wdata = map_wr;

   always_comb begin
      adv_cur  = cur_ff;
      adv_fol  = fol_ff;
      adv_none = none_ff;
      adv_free = free_ff;
      if (!none_ff) begin
         adv_free = (free_ff == '0) ? free_ff : free_ff - FREE_W'(1);
         adv_cur  = fol_ff;
         if (adv_free <= FREE_W'(1)) begin
            adv_none = 1'b1;
         end else if (fol_ff == BLK_W'(pgftl_pkg::NUM_BLOCKS - 1)) begin
            adv_none = 1'b1;
         end else begin
            adv_fol = fol_ff + BLK_W'(1);
         end
      end
   end

   assign need = {1'b0, best_ff} + {1'b0, cwp_ff};

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      key_in    = key_ff;
      ob_in     = ob_ff;
      opg_in    = opg_ff;
      cur_in    = cur_ff;
      fol_in    = fol_ff;
      none_in   = none_ff;
      free_in   = free_ff;
      copies_in = copies_ff;
      scan_in   = scan_ff;
      best_in   = best_ff;
      vic_in    = vic_ff;
      have_in   = have_ff;
      cwp_in    = cwp_ff;
      cvc_in    = cvc_ff;
      page_in   = page_ff;
      gc_in     = gc_ff;
      adv_in    = adv_ff;
      rv_in     = 1'b0;
      rf_in     = rf_ff;
      rb_in     = rb_ff;
      rp_in     = rp_ff;
      rg_in     = rg_ff;

      map_we     = 1'b0;
      map_waddr  = key_ff;
      map_wr     = '0;
      map_raddr  = key_ff;
      pkey_we    = 1'b0;
      pkey_waddr = {cur_ff, cwp_ff[PG_W-1:0]};
      pkey_wdata = pkey_rdata;
      pkey_raddr = {vic_ff, page_ff};
      pval_we    = 1'b0;
      pval_waddr = {ob_ff, opg_ff};
      pval_wdata = 1'b0;
      pval_raddr = {vic_ff, page_ff};
      bvc_we     = 1'b0;
      bvc_waddr  = cur_ff;
      bvc_wdata  = '0;
      bvc_raddr  = cur_ff;
      wptr_we    = 1'b0;
      wptr_waddr = cur_ff;
      wptr_wdata = '0;
      wptr_raddr = cur_ff;
      alu_op     = pgftl_pkg::ALU_LT;
      alu_a      = bvc_rdata;
      alu_b      = best_ff;

      case (state_ff)
         S_CLR: begin
            map_we     = 1'b1;
            map_waddr  = clr_ff[KEY_W-1:0];
            pval_we    = 1'b1;
            pval_waddr = clr_ff;
            bvc_we     = 1'b1;
            bvc_waddr  = clr_ff[BLK_W-1:0];
            wptr_we    = 1'b1;
            wptr_waddr = clr_ff[BLK_W-1:0];
            clr_in     = clr_ff + PIDX_W'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            map_raddr = req_key;
            if (start) begin
               key_in   = req_key;
               gc_in    = 1'b0;
               adv_in   = 1'b0;
               state_in = req_func ? S_W_MAP : S_RD;
            end
         end
         S_RD: begin
            rv_in    = 1'b1;
            rf_in    = map_rd.ok;
            rb_in    = map_rd.ok ? map_rd.blk : '0;
            rp_in    = map_rd.ok ? map_rd.pg : '0;
            rg_in    = 1'b0;
            state_in = S_IDLE;
         end
         S_W_MAP: begin
            if (map_rd.ok) begin
               ob_in      = map_rd.blk;
               opg_in     = map_rd.pg;
               pval_raddr = {map_rd.blk, map_rd.pg};
               bvc_raddr  = map_rd.blk;
               map_we     = 1'b1;
               state_in   = S_W_OLD;
            end else begin
               state_in = S_GC_CHK;
            end
         end
         S_W_OLD: begin
            alu_op = pgftl_pkg::ALU_DEC_SAT;
            if (pval_rdata) begin
               pval_we   = 1'b1;
               bvc_we    = 1'b1;
               bvc_waddr = ob_ff;
               bvc_wdata = alu_res.res;
            end
            state_in = S_GC_CHK;
         end
         S_GC_CHK: begin
            state_in = (free_ff == FREE_W'(1)) ? S_GC_CUR : S_AP_RD;
         end
         S_GC_CUR: begin
            cwp_in   = wptr_rdata;
            cvc_in   = bvc_rdata;
            scan_in  = '0;
            best_in  = CNT_W'(pgftl_pkg::PAGES_PER_BLOCK);
            have_in  = 1'b0;
            vic_in   = '0;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            bvc_raddr = scan_ff;
            if (scan_ff == cur_ff) begin
               if (scan_ff == BLK_W'(pgftl_pkg::NUM_BLOCKS - 1)) begin
                  state_in = S_GC_DEC;
               end else begin
                  scan_in = scan_ff + BLK_W'(1);
               end
            end else begin
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (alu_res.flag) begin
               best_in = bvc_rdata;
               vic_in  = scan_ff;
               have_in = 1'b1;
            end
            // first empty block ends the search
            if ((alu_res.flag && bvc_rdata == '0) ||
                scan_ff == BLK_W'(pgftl_pkg::NUM_BLOCKS - 1)) begin
               state_in = S_GC_DEC;
            end else begin
               scan_in  = scan_ff + BLK_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_GC_DEC: begin
            page_in = '0;
            if (!have_ff || need > (CNT_W + 1)'(pgftl_pkg::PAGES_PER_BLOCK)) begin
               state_in = S_AP_RD;
            end else begin
               state_in = S_CP_RD;
            end
         end
         S_CP_RD: begin
            state_in = S_CP_WR;
         end
         S_CP_WR: begin
            if (pval_rdata && cwp_ff < CNT_W'(pgftl_pkg::PAGES_PER_BLOCK)) begin
               pkey_we    = 1'b1;
               pval_we    = 1'b1;
               pval_waddr = {cur_ff, cwp_ff[PG_W-1:0]};
               pval_wdata = 1'b1;
               map_we     = 1'b1;
               map_waddr  = pkey_rdata;
               map_wr.ok  = 1'b1;
               map_wr.blk = cur_ff;
               map_wr.pg  = cwp_ff[PG_W-1:0];
               cwp_in     = cwp_ff + CNT_W'(1);
               cvc_in     = cvc_ff + CNT_W'(1);
               if (copies_ff != '1) begin
                  copies_in = copies_ff + COPY_W'(1);
               end
            end
            state_in = S_CP_CLR;
         end
         S_CP_CLR: begin
            pval_we    = 1'b1;
            pval_waddr = {vic_ff, page_ff};
            if (page_ff == PG_W'(pgftl_pkg::PAGES_PER_BLOCK - 1)) begin
               state_in = S_FIN_VIC;
            end else begin
               page_in  = page_ff + PG_W'(1);
               state_in = S_CP_RD;
            end
         end
         S_FIN_VIC: begin
            bvc_we     = 1'b1;
            bvc_waddr  = vic_ff;
            wptr_we    = 1'b1;
            wptr_waddr = vic_ff;
            state_in   = S_FIN_CUR;
         end
         S_FIN_CUR: begin
            bvc_we     = 1'b1;
            bvc_wdata  = cvc_ff;
            wptr_we    = 1'b1;
            wptr_wdata = cwp_ff;
            if (free_ff < FREE_W'(pgftl_pkg::NUM_BLOCKS)) begin
               free_in = free_ff + FREE_W'(1);
            end
            fol_in   = vic_ff;
            none_in  = 1'b0;
            gc_in    = 1'b1;
            state_in = S_AP_RD;
         end
         S_AP_RD: begin
            state_in = S_AP_WR;
         end
         S_AP_WR: begin
            alu_op = pgftl_pkg::ALU_INC;
            if (wptr_rdata >= CNT_W'(pgftl_pkg::PAGES_PER_BLOCK)) begin
               if (!adv_ff) begin
                  cur_in   = adv_cur;
                  fol_in   = adv_fol;
                  none_in  = adv_none;
                  free_in  = adv_free;
                  adv_in   = 1'b1;
                  state_in = S_AP_RD;
               end else begin
                  // no room anywhere: the write is dropped
                  rv_in    = 1'b1;
                  rf_in    = 1'b0;
                  rb_in    = '0;
                  rp_in    = '0;
                  rg_in    = gc_ff;
                  state_in = S_IDLE;
               end
            end else begin
               pkey_we    = 1'b1;
               pkey_waddr = {cur_ff, wptr_rdata[PG_W-1:0]};
               pkey_wdata = key_ff;
               pval_we    = 1'b1;
               pval_waddr = {cur_ff, wptr_rdata[PG_W-1:0]};
               pval_wdata = 1'b1;
               bvc_we     = 1'b1;
               bvc_wdata  = alu_res.res;
               wptr_we    = 1'b1;
               wptr_wdata = wptr_rdata + CNT_W'(1);
               map_we     = 1'b1;
               map_wr.ok  = 1'b1;
               map_wr.blk = cur_ff;
               map_wr.pg  = wptr_rdata[PG_W-1:0];
               rv_in      = 1'b1;
               rf_in      = 1'b1;
               rb_in      = cur_ff;
               rp_in      = wptr_rdata[PG_W-1:0];
               rg_in      = gc_ff;
               if (wptr_wdata == CNT_W'(pgftl_pkg::PAGES_PER_BLOCK)) begin
                  cur_in  = adv_cur;
                  fol_in  = adv_fol;
                  none_in = adv_none;
                  free_in = adv_free;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         clr_ff    <= '0;
         cur_ff    <= '0;
         fol_ff    <= BLK_W'(1);
         none_ff   <= 1'b0;
         free_ff   <= FREE_W'(pgftl_pkg::NUM_BLOCKS);
         copies_ff <= '0;
         gc_ff     <= 1'b0;
         adv_ff    <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         cur_ff    <= cur_in;
         fol_ff    <= fol_in;
         none_ff   <= none_in;
         free_ff   <= free_in;
         copies_ff <= copies_in;
         gc_ff     <= gc_in;
         adv_ff    <= adv_in;
         rv_ff     <= rv_in;
      end
      key_ff  <= key_in;
      ob_ff   <= ob_in;
      opg_ff  <= opg_in;
      scan_ff <= scan_in;
      best_ff <= best_in;
      vic_ff  <= vic_in;
      have_ff <= have_in;
      cwp_ff  <= cwp_in;
      cvc_ff  <= cvc_in;
      page_ff <= page_in;
      rf_ff   <= rf_in;
      rb_ff   <= rb_in;
      rp_ff   <= rp_in;
      rg_ff   <= rg_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rv_ff;
   assign rsp_found      = rf_ff;
   assign rsp_phys_block = rb_ff;
   assign rsp_phys_page  = rp_ff;
   assign rsp_gc_ran     = rg_ff;
   assign rsp_copy_count = copies_ff;
endmodule

// File: sv/pgftl_ram.sv
// generic single write, single read memory with registered read data
`timescale 1ns / 1ps
module pgftl_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem_ff [2**ADDR_W];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: sv/pgftl_alu.sv
// shared count unit: saturating decrement, increment and less-than compare
`timescale 1ns / 1ps
module pgftl_alu (
   input  pgftl_pkg::alu_op_type          op,
   input  logic [pgftl_pkg::CNT_W-1:0]    a,
   input  logic [pgftl_pkg::CNT_W-1:0]    b,
   output pgftl_pkg::alu_res_type         result
);
   always_comb begin
      result = '0;
      case (op)
         pgftl_pkg::ALU_DEC_SAT: begin
            result.res  = (a == '0) ? a : a - pgftl_pkg::CNT_W'(1);
            result.flag = (a == '0);
         end
         pgftl_pkg::ALU_INC: begin
            result.res  = a + pgftl_pkg::CNT_W'(1);
            result.flag = 1'b0;
         end
         pgftl_pkg::ALU_LT: begin
            result.res  = a;
            result.flag = (a < b);
         end
         default: begin
            result = '0;
         end
      endcase
   end
endmodule

// File: sv/pgftl_checker.sv
// port-level checks of the translation core, bound to the top level
`timescale 1ns / 1ps
module pgftl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic                        rsp_found,
   input logic [pgftl_pkg::BLK_W-1:0] rsp_phys_block,
   input logic [pgftl_pkg::PG_W-1:0]  rsp_phys_page
);
   // an accepted item must raise busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted item did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result shown while busy");

   // one result per item, never two in a row
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held two cycles");

   a_unmapped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_phys_block == '0 && rsp_phys_page == '0)
      else $error("unmapped result carries a location");
endmodule

bind page_mapped_ftl_greedy_gc_core pgftl_checker u_pgftl_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_found(rsp_found),
   .rsp_phys_block(rsp_phys_block),
   .rsp_phys_page(rsp_phys_page)
);

// File: tb/tb_top.sv
// testbench for the page-mapped translation core with greedy garbage collection
`timescale 1ns / 1ps
module tb_top;
   localparam int NUM_BLOCKS      = pgftl_pkg::NUM_BLOCKS;
   localparam int PAGES_PER_BLOCK = pgftl_pkg::PAGES_PER_BLOCK;
   localparam int NUM_KEYS        = pgftl_pkg::NUM_KEYS;
   localparam int BLK_W           = pgftl_pkg::BLK_W;
   localparam int PG_W            = pgftl_pkg::PG_W;
   localparam int KEY_W           = pgftl_pkg::KEY_W;

   typedef struct packed {
      logic             found;
      logic [BLK_W-1:0] blk;
      logic [PG_W-1:0]  pg;
      logic             gc;
      logic [31:0]      copies;
   } lookup_type;

   typedef struct {
      logic             func;
      logic [KEY_W-1:0] key;
      bit               typed;
      lookup_type       res;
   } dir_row_type;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;
   localparam int   RAND_ITEMS = 1284;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic             req_func = OP_READ;
   logic [KEY_W-1:0] req_key = '0;
   logic             rsp_valid, rsp_found, rsp_gc_ran;
   logic [BLK_W-1:0] rsp_phys_block;
   logic [PG_W-1:0]  rsp_phys_page;
   logic [31:0]      rsp_copy_count;

   // model state of the translation tables
   bit          mdl_ok [NUM_KEYS];
   int unsigned mdl_blk [NUM_KEYS];
   int unsigned mdl_pg [NUM_KEYS];
   int unsigned pg_owner [NUM_BLOCKS*PAGES_PER_BLOCK];
   bit          pg_live [NUM_BLOCKS*PAGES_PER_BLOCK];
   int unsigned blk_live [NUM_BLOCKS];
   int unsigned blk_wp [NUM_BLOCKS];
   int unsigned cur_blk, next_blk, free_cnt, copies;
   bit          next_none;

   lookup_type  pending_q[$];
   bit          item_typed;
   lookup_type  item_res;
   int          errors = 0;
   int          n_reads = 0, n_writes = 0, n_gc = 0;

   page_mapped_ftl_greedy_gc_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_found(rsp_found), .rsp_phys_block(rsp_phys_block),
      .rsp_phys_page(rsp_phys_page), .rsp_gc_ran(rsp_gc_ran),
      .rsp_copy_count(rsp_copy_count)
   );

   always #1 clock = ~clock;

   initial begin
      #4000000;
      $display("timeout");
      $display("[page_mapped_ftl_greedy_gc_core] ERROR");
      $finish;
   end

   function automatic void model_clear();
      for (int k = 0; k < NUM_KEYS; k++) begin
         mdl_ok[k] = 0; mdl_blk[k] = 0; mdl_pg[k] = 0;
      end
      for (int p = 0; p < NUM_BLOCKS*PAGES_PER_BLOCK; p++) begin
         pg_owner[p] = 0; pg_live[p] = 0;
      end
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         blk_live[b] = 0; blk_wp[b] = 0;
      end
      cur_blk = 0; next_blk = 1; next_none = 0;
      free_cnt = NUM_BLOCKS; copies = 0;
   endfunction

   function automatic void step_block();
      if (next_none) return;
      if (free_cnt > 0) free_cnt--;
      cur_blk = next_blk % NUM_BLOCKS;
      if (free_cnt <= 1) next_none = 1;
      else begin
         next_blk++;
         if (next_blk >= NUM_BLOCKS) next_none = 1;
      end
   endfunction

   function automatic bit collect_block();
      int unsigned cur, room, best, victim, src, dst, k, dpg;
      bit have;
      cur = cur_blk % NUM_BLOCKS;
      room = (blk_wp[cur] < PAGES_PER_BLOCK) ? PAGES_PER_BLOCK - blk_wp[cur] : 0;
      best = PAGES_PER_BLOCK;
      victim = 0;
      have = 0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         if (b != cur && blk_live[b] < best) begin
            best = blk_live[b]; victim = b; have = 1;
            if (best == 0) break;
         end
      end
      if (!have || best > room) return 0;
      for (int p = 0; p < PAGES_PER_BLOCK; p++) begin
         src = victim * PAGES_PER_BLOCK + p;
         if (pg_live[src] && blk_wp[cur] < PAGES_PER_BLOCK) begin
            dpg = blk_wp[cur];
            dst = cur * PAGES_PER_BLOCK + dpg;
            k = pg_owner[src];
            pg_owner[dst] = k; pg_live[dst] = 1;
            blk_live[cur]++; blk_wp[cur]++;
            if (copies != 32'hFFFF_FFFF) copies++;
            mdl_ok[k] = 1; mdl_blk[k] = cur; mdl_pg[k] = dpg;
         end
         pg_live[src] = 0;
      end
      blk_live[victim] = 0;
      blk_wp[victim] = 0;
      if (free_cnt < NUM_BLOCKS) free_cnt++;
      next_blk = victim;
      next_none = 0;
      return 1;
   endfunction

   function automatic lookup_type lookup_or_store(logic func, logic [KEY_W-1:0] key);
      lookup_type r;
      int unsigned ob, idx, cur, wp;
      r = '0;
      if (func == OP_READ) begin
         if (mdl_ok[key]) begin
            r.found = 1'b1; r.blk = BLK_W'(mdl_blk[key]); r.pg = PG_W'(mdl_pg[key]);
         end
      end else begin
         if (mdl_ok[key]) begin
            ob = mdl_blk[key] % NUM_BLOCKS;
            idx = ob * PAGES_PER_BLOCK + mdl_pg[key] % PAGES_PER_BLOCK;
            if (pg_live[idx]) begin
               pg_live[idx] = 0;
               if (blk_live[ob] > 0) blk_live[ob]--;
            end
            mdl_ok[key] = 0;
         end
         if (free_cnt == 1) r.gc = collect_block();
         cur = cur_blk % NUM_BLOCKS;
         if (blk_wp[cur] >= PAGES_PER_BLOCK) begin
            step_block();
            cur = cur_blk % NUM_BLOCKS;
         end
         if (blk_wp[cur] < PAGES_PER_BLOCK) begin
            wp = blk_wp[cur];
            idx = cur * PAGES_PER_BLOCK + wp;
            pg_owner[idx] = key; pg_live[idx] = 1;
            blk_live[cur]++;
            mdl_ok[key] = 1; mdl_blk[key] = cur; mdl_pg[key] = wp;
            r.found = 1'b1; r.blk = BLK_W'(cur); r.pg = PG_W'(wp);
            blk_wp[cur] = wp + 1;
            if (blk_wp[cur] == PAGES_PER_BLOCK) step_block();
         end
      end
      r.copies = copies;
      return r;
   endfunction

   // check results, then take accepted items
   always @(posedge clock) begin
      lookup_type want, pred;
      if (!reset && rsp_valid) begin
         if (pending_q.size() == 0) begin
            $display("%0t: result with no item outstanding", $time);
            errors++;
         end else begin
            want = pending_q.pop_front();
            if (rsp_found !== want.found || rsp_phys_block !== want.blk ||
                rsp_phys_page !== want.pg || rsp_gc_ran !== want.gc ||
                rsp_copy_count !== want.copies) begin
               $display("%0t: mismatch exp found=%0d blk=%0d pg=%0d gc=%0d cnt=%0d",
                        $time, want.found, want.blk, want.pg, want.gc, want.copies);
               $display("%0t:          got found=%0d blk=%0d pg=%0d gc=%0d cnt=%0d",
                        $time, rsp_found, rsp_phys_block, rsp_phys_page,
                        rsp_gc_ran, rsp_copy_count);
               errors++;
            end
            if (rsp_gc_ran) n_gc++;
         end
      end
      if (!reset && start && !busy) begin
         pred = lookup_or_store(req_func, req_key);
         pending_q.push_back(item_typed ? item_res : pred);
         if (req_func == OP_WRITE) n_writes++;
         else n_reads++;
      end
   end

   task automatic send_item(logic func, logic [KEY_W-1:0] key, bit typed,
                            lookup_type res, int idle_pct);
      int gap;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1; req_func = func; req_key = key;
      item_typed = typed; item_res = res;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start = 1'b0;
   endtask

   dir_row_type dir_tab[] = '{
      '{OP_READ,  10'd0,    1, '{1'b0, 6'd0, 5'd0, 1'b0, 32'd0}},
      '{OP_READ,  10'd1023, 1, '{1'b0, 6'd0, 5'd0, 1'b0, 32'd0}},
      '{OP_WRITE, 10'd0,    1, '{1'b1, 6'd0, 5'd0, 1'b0, 32'd0}},
      '{OP_WRITE, 10'd1023, 1, '{1'b1, 6'd0, 5'd1, 1'b0, 32'd0}},
      '{OP_READ,  10'd1023, 1, '{1'b1, 6'd0, 5'd1, 1'b0, 32'd0}},
      '{OP_READ,  10'd0,    1, '{1'b1, 6'd0, 5'd0, 1'b0, 32'd0}},
      '{OP_WRITE, 10'd0,    1, '{1'b1, 6'd0, 5'd2, 1'b0, 32'd0}},
      '{OP_READ,  10'd0,    1, '{1'b1, 6'd0, 5'd2, 1'b0, 32'd0}},
      '{OP_READ,  10'd512,  1, '{1'b0, 6'd0, 5'd0, 1'b0, 32'd0}},
      '{OP_WRITE, 10'd512,  0, '0},
      '{OP_WRITE, 10'd341,  0, '0},
      '{OP_WRITE, 10'd682,  0, '0},
      '{OP_READ,  10'd512,  0, '0},
      '{OP_READ,  10'd682,  0, '0},
      '{OP_WRITE, 10'd1023, 0, '0},
      '{OP_READ,  10'd1023, 0, '0}
   };

   initial begin
      int idle_pct;
      logic f;
      logic [KEY_W-1:0] k;
      model_clear();
      repeat (8) @(negedge clock);
      reset = 1'b0;
      foreach (dir_tab[i])
         send_item(dir_tab[i].func, dir_tab[i].key, dir_tab[i].typed, dir_tab[i].res, 0);
      // mostly writes so the blocks fill
      for (int i = 0; i < RAND_ITEMS; i++) begin
         idle_pct = (i < RAND_ITEMS/3) ? 34 : (i < 2*RAND_ITEMS/3) ? 76 : 0;
         f = ($urandom_range(99) < 85) ? OP_WRITE : OP_READ;
         k = ($urandom_range(99) < 60) ? KEY_W'($urandom_range(63)) : KEY_W'($urandom);
         send_item(f, k, 0, '0, idle_pct);
      end
      while (pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d reads and %0d writes, %0d collections, %0d pages copied",
               n_reads, n_writes, n_gc, copies);
      if (errors == 0)
         $display("[page_mapped_ftl_greedy_gc_core] OK");
      else
         $display("[page_mapped_ftl_greedy_gc_core] ERROR");
      $finish;
   end
endmodule
